FILE: design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is applied
`define MPFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define MPFB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mpfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpfb_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;

    localparam int ADDR_W  = $clog2(STORE_SIZE);
    localparam int COL_W   = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ROW_W   = PAGE_W + 3;
    // holds x + w - 1 up to 509 and a mirrored corner down to -446
    localparam int COORD_W = 11;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } box_t;

    localparam coord_t COORD_ZERO = coord_t'(0);
    localparam coord_t COL_MAX    = coord_t'(SCREEN_WIDTH - 1);
    localparam coord_t ROW_MAX    = coord_t'(SCREEN_HEIGHT - 1);

    localparam logic [7:0] BYTE_ONES        = 8'hFF;
    localparam logic [2:0] ROW_IN_PAGE_MAX  = 3'h7;

    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_RECT  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_XOR   = 2'd2;
    localparam logic [1:0] MODE_KEEP  = 2'd3;

    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_90   = 2'd1;
    localparam logic [1:0] ROT_180  = 2'd2;
    localparam logic [1:0] ROT_270  = 2'd3;

endpackage

`default_nettype wire

FILE: design/mpfb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mpfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/mpfb_geom.sv
`timescale 1ns / 1ps
`default_nettype none

module mpfb_geom (
    input  logic [1:0]    rotation,
    input  logic          is_rect,
    input  logic [7:0]    pos_x,
    input  logic [7:0]    pos_y,
    input  logic [7:0]    rect_width,
    input  logic [7:0]    rect_height,
    output mpfb_pkg::box_t box
);
    import mpfb_pkg::*;

    point_t corner_a;
    point_t corner_b;
    point_t turned_a;
    point_t turned_b;

    function automatic point_t turn(point_t p, logic [1:0] rot);
        point_t q;
        q = p;
        case (rot)
            ROT_90: begin
                q.x = COL_MAX - p.y;
                q.y = p.x;
            end
            ROT_180: begin
                q.x = COL_MAX - p.x;
                q.y = ROW_MAX - p.y;
            end
            ROT_270: begin
                q.x = p.y;
                q.y = ROW_MAX - p.x;
            end
            default: q = p;
        endcase
        return q;
    endfunction

    always_comb begin
        corner_a.x = coord_t'(pos_x);
        corner_a.y = coord_t'(pos_y);
        // a pixel is a one by one box
        if (is_rect) begin
            corner_b.x = coord_t'(pos_x) + coord_t'(rect_width) - coord_t'(1);
            corner_b.y = coord_t'(pos_y) + coord_t'(rect_height) - coord_t'(1);
        end else begin
            corner_b = corner_a;
        end
        turned_a = turn(corner_a, rotation);
        turned_b = turn(corner_b, rotation);

        box.x1 = (turned_a.x > turned_b.x) ? turned_b.x : turned_a.x;
        box.x2 = (turned_a.x > turned_b.x) ? turned_a.x : turned_b.x;
        box.y1 = (turned_a.y > turned_b.y) ? turned_b.y : turned_a.y;
        box.y2 = (turned_a.y > turned_b.y) ? turned_a.y : turned_b.y;
    end

endmodule

`default_nettype wire

FILE: design/mono_page_framebuffer_draw.sv
`timescale 1ns / 1ps
`default_nettype none
// pixel draw: states ROT, CLIP, WALK (skipped on a miss), FINISH; ready again once the result is out
// rectangle: walks pages x columns, one byte read-modify-write per cycle on the ram port
// read: states ROT, CLIP, RDDATA, FINISH; every result waits in FINISH while the output stalls
// reset: sync active low, rotation back to 0, then a clearing pass
// zeroes the whole store one byte a cycle; no input is taken until it ends

module mono_page_framebuffer_draw (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    input  logic [7:0] s_rect_width,
    input  logic [7:0] s_rect_height,
    input  logic [1:0] s_draw_mode,
    input  logic [2:0] s_read_page,
    input  logic [6:0] s_read_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_drawn
);
    import mpfb_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_ROT    = 7'b0000100,
        ST_CLIP   = 7'b0001000,
        ST_WALK   = 7'b0010000,
        ST_RDDATA = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_SIZE - 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [1:0]          rotation_reg, rotation_next;
    logic                m_valid_reg, m_valid_next;
    logic                wr_pend_reg, wr_pend_next;

    // item held for the duration of the operation
    logic [1:0] func_reg;
    logic [7:0] pos_x_reg;
    logic [7:0] pos_y_reg;
    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic [1:0] mode_reg;
    logic [2:0] rpage_reg;
    logic [6:0] rcol_reg;

    box_t              box_now;
    box_t              box_reg;
    logic [COL_W-1:0]  cx1_reg, cx2_reg, col_reg;
    logic [ROW_W-1:0]  cy1_reg, cy2_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              rd_ok_reg;
    logic [7:0]        res_data_reg;
    logic              res_drawn_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [7:0]        wr_mask_reg;
    logic [7:0]        m_read_data_reg;
    logic              m_drawn_reg;

    coord_t            cx1_c, cx2_c, cy1_c, cy2_c;
    logic              draw_ok;
    logic              hit;
    logic              rd_ok;
    logic [PAGE_W-1:0] page_last;
    logic [2:0]        row_lo, row_hi;
    logic [7:0]        page_mask;
    logic [ADDR_W-1:0] walk_addr, byte_addr, ram_rd_addr, ram_wr_addr;
    logic [7:0]        ram_rd_data, ram_wr_data, modified;
    logic              ram_wr_en;
    logic              out_free;

    function automatic coord_t clamp(coord_t v, coord_t hi);
        coord_t r;
        if (v < COORD_ZERO) begin
            r = COORD_ZERO;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    mpfb_geom u_geom (
        .rotation    (rotation_reg),
        .is_rect     (func_reg == FUNC_RECT),
        .pos_x       (pos_x_reg),
        .pos_y       (pos_y_reg),
        .rect_width  (width_reg),
        .rect_height (height_reg),
        .box         (box_now)
    );

    mpfb_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_SIZE)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // clipping of the rotated box and the read address check
    always_comb begin
        draw_ok = (func_reg == FUNC_PIXEL) ||
                  ((func_reg == FUNC_RECT) && (width_reg != 8'd0) && (height_reg != 8'd0));
        hit = draw_ok && !((box_reg.x1 > COL_MAX) || (box_reg.x2 < COORD_ZERO) ||
                           (box_reg.y1 > ROW_MAX) || (box_reg.y2 < COORD_ZERO));
        cx1_c = clamp(box_reg.x1, COL_MAX);
        cx2_c = clamp(box_reg.x2, COL_MAX);
        cy1_c = clamp(box_reg.y1, ROW_MAX);
        cy2_c = clamp(box_reg.y2, ROW_MAX);
        rd_ok = (6'(rpage_reg) < 6'(PAGE_COUNT)) && (9'(rcol_reg) < 9'(SCREEN_WIDTH));
        byte_addr = ADDR_W'(rpage_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(rcol_reg);
    end

    // mask of covered rows in the current page and its byte address
    always_comb begin
        page_last = cy2_reg[ROW_W-1:3];
        row_lo = (page_reg == cy1_reg[ROW_W-1:3]) ? cy1_reg[2:0] : 3'd0;
        row_hi = (page_reg == page_last) ? cy2_reg[2:0] : ROW_IN_PAGE_MAX;
        page_mask = (BYTE_ONES << row_lo) & (BYTE_ONES >> (ROW_IN_PAGE_MAX - row_hi));
        walk_addr = ADDR_W'(page_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_reg);
    end

    always_comb begin
        case (mode_reg)
            MODE_CLEAR: modified = ram_rd_data & ~wr_mask_reg;
            MODE_SET:   modified = ram_rd_data | wr_mask_reg;
            MODE_XOR:   modified = ram_rd_data ^ wr_mask_reg;
            MODE_KEEP:  modified = ram_rd_data;
            default:    modified = ram_rd_data;
        endcase
    end

    // bytes of one box never repeat and the next item reads only after the
    // last write-back, so the read port never meets a pending write
    always_comb begin
        ram_rd_addr = (state_reg == ST_CLIP) ? byte_addr : walk_addr;
        ram_wr_en   = (state_reg == ST_CLEAR) || wr_pend_reg;
        ram_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : wr_addr_reg;
        ram_wr_data = (state_reg == ST_CLEAR) ? 8'd0 : modified;
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        rotation_next = cfg_wr_en ? cfg_wr_data : rotation_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        wr_pend_next  = (state_reg == ST_WALK);
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                state_next = ST_CLIP;
            end
            ST_CLIP: begin
                if (func_reg == FUNC_READ) begin
                    state_next = ST_RDDATA;
                end else if (hit) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_WALK: begin
                if ((col_reg == cx2_reg) && (page_reg == page_last)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_RDDATA: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            rotation_reg <= ROT_NONE;
            m_valid_reg  <= 1'b0;
            wr_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            rotation_reg <= rotation_next;
            m_valid_reg  <= m_valid_next;
            wr_pend_reg  <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg   <= s_func;
            pos_x_reg  <= s_pos_x;
            pos_y_reg  <= s_pos_y;
            width_reg  <= s_rect_width;
            height_reg <= s_rect_height;
            mode_reg   <= s_draw_mode;
            rpage_reg  <= s_read_page;
            rcol_reg   <= s_read_column;
        end
        if (state_reg == ST_ROT) begin
            box_reg <= box_now;
        end
        if (state_reg == ST_CLIP) begin
            cx1_reg       <= cx1_c[COL_W-1:0];
            cx2_reg       <= cx2_c[COL_W-1:0];
            cy1_reg       <= cy1_c[ROW_W-1:0];
            cy2_reg       <= cy2_c[ROW_W-1:0];
            col_reg       <= cx1_c[COL_W-1:0];
            page_reg      <= cy1_c[ROW_W-1:3];
            rd_ok_reg     <= rd_ok;
            res_data_reg  <= 8'd0;
            res_drawn_reg <= hit && (func_reg != FUNC_READ);
        end
        if (state_reg == ST_WALK) begin
            wr_addr_reg <= walk_addr;
            wr_mask_reg <= page_mask;
            if (col_reg == cx2_reg) begin
                col_reg  <= cx1_reg;
                page_reg <= page_reg + PAGE_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
        if (state_reg == ST_RDDATA) begin
            res_data_reg <= rd_ok_reg ? ram_rd_data : 8'd0;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_read_data_reg <= res_data_reg;
            m_drawn_reg     <= res_drawn_reg;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_drawn     = m_drawn_reg;

endmodule

`default_nettype wire

FILE: design/mpfb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mpfb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_drawn
);

    // one item in flight: ready drops right after each input transfer
    `MPFB_ASSERT(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input taken while busy")

    `MPFB_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_drawn), "stalled result changed")

    // draws never return buffer data
    `MPFB_ASSERT(a_draw_no_data, aclk, aresetn, m_valid && m_drawn |-> m_read_data == 8'd0, "draw result carries data")

    // reset starts the clearing pass with both channels quiet
    `MPFB_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !s_ready && !m_valid, "channel active after reset")

endmodule

bind mono_page_framebuffer_draw mpfb_checker u_mpfb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_drawn     (m_drawn)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mpfb_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [1:0] func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] rect_w;
        logic [7:0] rect_h;
        logic [1:0] mode;
        logic [2:0] page;
        logic [6:0] column;
    } draw_cmd_t;

    typedef struct {
        logic [7:0] read_data;
        logic       drawn;
    } reply_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = ROT_NONE;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_func = FUNC_PIXEL;
    logic [7:0] s_pos_x = '0;
    logic [7:0] s_pos_y = '0;
    logic [7:0] s_rect_width = '0;
    logic [7:0] s_rect_height = '0;
    logic [1:0] s_draw_mode = MODE_CLEAR;
    logic [2:0] s_read_page = '0;
    logic [6:0] s_read_column = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic       m_drawn;

    draw_cmd_t  pending_cmds[$];
    reply_t     due_replies[$];
    logic [7:0] shadow_fb [STORE_SIZE];
    logic [1:0] rotation_setting = ROT_NONE;
    logic       idle_off = 1'b0;
    logic       rx_hold = 1'b0;
    int         send_gap = 0;
    int         stall_left = 0;
    int         accepted_cmds = 0;
    int         fail_count = 0;
    int         cycle_count = 0;

    mono_page_framebuffer_draw u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .s_draw_mode   (s_draw_mode),
        .s_read_page   (s_read_page),
        .s_read_column (s_read_column),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_drawn       (m_drawn)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void turn_point(input logic [1:0] rot, inout int x, inout int y);
        int ox;
        int oy;
        ox = x;
        oy = y;
        case (rot)
            ROT_90: begin
                x = SCREEN_WIDTH - oy - 1;
                y = ox;
            end
            ROT_180: begin
                x = SCREEN_WIDTH - ox - 1;
                y = SCREEN_HEIGHT - oy - 1;
            end
            ROT_270: begin
                x = oy;
                y = SCREEN_HEIGHT - ox - 1;
            end
            default: ;
        endcase
    endfunction

    function automatic int clip(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void touch_byte(input int col, input int page, input logic [7:0] mask,
                                       input logic [1:0] mode);
        int idx;
        idx = page * SCREEN_WIDTH + col;
        case (mode)
            MODE_CLEAR: shadow_fb[idx] = shadow_fb[idx] & ~mask;
            MODE_SET:   shadow_fb[idx] = shadow_fb[idx] | mask;
            MODE_XOR:   shadow_fb[idx] = shadow_fb[idx] ^ mask;
            default: ;
        endcase
    endfunction

    // paints the command into the shadow buffer and returns the reply it owes
    function automatic reply_t render_cmd(input draw_cmd_t c);
        reply_t     r;
        int         x1, y1, x2, y2, t, pg, col, top, lo, hi;
        logic [7:0] mask;
        r.read_data = '0;
        r.drawn = 1'b0;
        case (c.func)
            FUNC_PIXEL: begin
                x1 = int'(c.pos_x);
                y1 = int'(c.pos_y);
                turn_point(rotation_setting, x1, y1);
                if (x1 >= 0 && x1 < SCREEN_WIDTH && y1 >= 0 && y1 < SCREEN_HEIGHT) begin
                    mask = 8'h01 << (y1 % 8);
                    touch_byte(x1, y1 / 8, mask, c.mode);
                    r.drawn = 1'b1;
                end
            end
            FUNC_RECT: begin
                if (c.rect_w != 8'd0 && c.rect_h != 8'd0) begin
                    x1 = int'(c.pos_x);
                    y1 = int'(c.pos_y);
                    x2 = int'(c.pos_x) + int'(c.rect_w) - 1;
                    y2 = int'(c.pos_y) + int'(c.rect_h) - 1;
                    turn_point(rotation_setting, x1, y1);
                    turn_point(rotation_setting, x2, y2);
                    if (x1 > x2) begin
                        t = x1;
                        x1 = x2;
                        x2 = t;
                    end
                    if (y1 > y2) begin
                        t = y1;
                        y1 = y2;
                        y2 = t;
                    end
                    if (!(x1 > SCREEN_WIDTH - 1 || x2 < 0 || y1 > SCREEN_HEIGHT - 1 || y2 < 0)) begin
                        x1 = clip(x1, SCREEN_WIDTH - 1);
                        x2 = clip(x2, SCREEN_WIDTH - 1);
                        y1 = clip(y1, SCREEN_HEIGHT - 1);
                        y2 = clip(y2, SCREEN_HEIGHT - 1);
                        for (pg = y1 / 8; pg <= y2 / 8; pg++) begin
                            top = pg * 8;
                            lo = (y1 > top) ? y1 - top : 0;
                            hi = (y2 < top + 7) ? y2 - top : 7;
                            mask = (BYTE_ONES << lo) & (BYTE_ONES >> (7 - hi));
                            for (col = x1; col <= x2; col++)
                                touch_byte(col, pg, mask, c.mode);
                        end
                        r.drawn = 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                if (int'(c.page) < PAGE_COUNT && int'(c.column) < SCREEN_WIDTH)
                    r.read_data = shadow_fb[int'(c.page) * SCREEN_WIDTH + int'(c.column)];
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: one command per transfer, payload held while valid is up
    always @(posedge aclk) begin : sender
        draw_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                c.func = s_func;
                c.pos_x = s_pos_x;
                c.pos_y = s_pos_y;
                c.rect_w = s_rect_width;
                c.rect_h = s_rect_height;
                c.mode = s_draw_mode;
                c.page = s_read_page;
                c.column = s_read_column;
                due_replies.push_back(render_cmd(c));
                accepted_cmds++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    s_func <= c.func;
                    s_pos_x <= c.pos_x;
                    s_pos_y <= c.pos_y;
                    s_rect_width <= c.rect_w;
                    s_rect_height <= c.rect_h;
                    s_draw_mode <= c.mode;
                    s_read_page <= c.page;
                    s_read_column <= c.column;
                    s_valid <= 1'b1;
                    send_gap <= pick_idle();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transfer against the oldest owed reply
    always @(posedge aclk) begin : receiver
        reply_t want;
        int     gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_replies.size() == 0) begin
                    $display("%0t: result with nothing owed, read_data %02h drawn %0b",
                             $time, m_read_data, m_drawn);
                    fail_count++;
                end else begin
                    want = due_replies.pop_front();
                    if (m_read_data !== want.read_data) begin
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, want.read_data, m_read_data);
                        fail_count++;
                    end
                    if (m_drawn !== want.drawn) begin
                        $display("%0t: drawn mismatch, expected %0b, got %0b",
                                 $time, want.drawn, m_drawn);
                        fail_count++;
                    end
                end
            end
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                gap = pick_idle();
                stall_left <= gap;
                m_ready <= (gap == 0);
            end
        end
    end

    // long receiver stall while the sender keeps offering, so the input backs up
    initial begin : rx_hold_ctl
        int held;
        wait (accepted_cmds >= 300);
        @(posedge aclk);
        rx_hold <= 1'b1;
        for (held = 0; held < 400; held++)
            @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void queue_cmd(input logic [1:0] func, input int x, input int y,
                                      input int w, input int h, input logic [1:0] mode,
                                      input int page, input int column);
        draw_cmd_t c;
        c.func = func;
        c.pos_x = 8'(x);
        c.pos_y = 8'(y);
        c.rect_w = 8'(w);
        c.rect_h = 8'(h);
        c.mode = mode;
        c.page = 3'(page);
        c.column = 7'(column);
        pending_cmds.push_back(c);
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 127);
        return $urandom_range(0, 255);
    endfunction

    // mostly small boxes, a few huge ones, the odd zero size
    function automatic int rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (r < 84) return $urandom_range(1, 16);
        return $urandom_range(0, 255);
    endfunction

    function automatic void queue_random();
        draw_cmd_t c;
        int        r, x, y;
        r = $urandom_range(0, 99);
        c.func = (r < 35) ? FUNC_PIXEL : (r < 70) ? FUNC_RECT : (r < 95) ? FUNC_READ : FUNC_NONE;
        c.pos_x = 8'(rand_coord());
        c.pos_y = 8'(rand_coord());
        c.rect_w = 8'(rand_size());
        c.rect_h = 8'(rand_size());
        c.mode = 2'($urandom_range(MODE_CLEAR, MODE_KEEP));
        c.page = 3'($urandom_range(0, PAGE_COUNT - 1));
        c.column = 7'($urandom_range(0, SCREEN_WIDTH - 1));
        pending_cmds.push_back(c);
        // read back the byte a pixel landed in
        if (c.func == FUNC_PIXEL && $urandom_range(0, 9) < 4) begin
            x = int'(c.pos_x);
            y = int'(c.pos_y);
            turn_point(rotation_setting, x, y);
            if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT)
                queue_cmd(FUNC_READ, rand_coord(), rand_coord(), rand_size(), rand_size(),
                          2'($urandom_range(MODE_CLEAR, MODE_KEEP)), y / 8, x);
        end
    endfunction

    task automatic drain();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || due_replies.size() != 0);
    endtask

    task automatic set_rotation(input logic [1:0] rot);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= rot;
        rotation_setting = rot;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [1:0] rot_plan [4];
        int         ph;
        int         n;
        rot_plan = '{ROT_90, ROT_180, ROT_270, ROT_NONE};
        foreach (shadow_fb[i])
            shadow_fb[i] = 8'h00;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // the store is cleared after reset before any input is taken
        do @(negedge aclk);
        while (!s_ready);
        set_rotation(ROT_NONE);

        queue_cmd(FUNC_PIXEL, 0, 0, 1, 1, MODE_SET, 0, 0);
        queue_cmd(FUNC_PIXEL, 127, 63, 1, 1, MODE_SET, 0, 0);
        queue_cmd(FUNC_PIXEL, 128, 5, 1, 1, MODE_SET, 0, 0);
        queue_cmd(FUNC_PIXEL, 255, 255, 255, 255, MODE_XOR, 0, 0);
        queue_cmd(FUNC_READ, 0, 0, 0, 0, MODE_CLEAR, 0, 0);
        queue_cmd(FUNC_READ, 0, 0, 0, 0, MODE_CLEAR, 7, 127);
        queue_cmd(FUNC_PIXEL, 0, 0, 1, 1, MODE_XOR, 0, 0);
        queue_cmd(FUNC_PIXEL, 127, 63, 1, 1, MODE_KEEP, 0, 0);
        queue_cmd(FUNC_PIXEL, 127, 63, 1, 1, MODE_CLEAR, 0, 0);
        queue_cmd(FUNC_RECT, 3, 5, 0, 10, MODE_SET, 0, 0);
        queue_cmd(FUNC_RECT, 3, 5, 10, 0, MODE_SET, 0, 0);
        queue_cmd(FUNC_RECT, 0, 0, 255, 255, MODE_SET, 0, 0);
        queue_cmd(FUNC_READ, 0, 0, 0, 0, MODE_CLEAR, 4, 64);
        queue_cmd(FUNC_RECT, 5, 3, 20, 12, MODE_XOR, 0, 0);
        queue_cmd(FUNC_READ, 0, 0, 0, 0, MODE_CLEAR, 0, 10);
        queue_cmd(FUNC_READ, 0, 0, 0, 0, MODE_CLEAR, 1, 10);
        queue_cmd(FUNC_RECT, 200, 10, 20, 20, MODE_SET, 0, 0);
        queue_cmd(FUNC_RECT, 100, 60, 255, 255, MODE_CLEAR, 0, 0);
        queue_cmd(FUNC_RECT, 0, 0, 255, 255, MODE_KEEP, 0, 0);
        queue_cmd(FUNC_RECT, 10, 10, 1, 1, MODE_CLEAR, 0, 0);
        queue_cmd(FUNC_NONE, 255, 255, 255, 255, MODE_KEEP, 7, 127);
        queue_cmd(FUNC_READ, 255, 255, 255, 255, MODE_KEEP, 7, 127);
        queue_cmd(FUNC_READ, 0, 0, 0, 0, MODE_CLEAR, 1, 10);
        queue_cmd(FUNC_READ, 0, 0, 0, 0, MODE_CLEAR, 1, 1);

        for (ph = 0; ph < 8; ph++) begin
            drain();
            repeat (8) @(posedge aclk);
            if (ph < 4)
                set_rotation(rot_plan[ph]);
            else
                set_rotation(2'($urandom_range(ROT_NONE, ROT_270)));
            idle_off = (ph == 3 || ph == 6);
            for (n = 0; n < 115; n++) begin
                // in odd phases, queuing stops halfway until every owed reply is in
                if (ph % 2 == 1 && n == 57)
                    drain();
                queue_random();
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
